// File: src/mac_address_filter_builder_macros.svh
// ---------------------------------------------------------------------------
// mac_address_filter_builder_macros.svh
// Assertion helpers shared by the address filter builder RTL.
// ---------------------------------------------------------------------------
`ifndef MAC_ADDRESS_FILTER_BUILDER_MACROS_SVH
`define MAC_ADDRESS_FILTER_BUILDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/maf_pkg.sv
// ---------------------------------------------------------------------------
// maf_pkg
// Types, constants and CRC helpers for the MAC address filter builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package maf_pkg;

  localparam int ADDR_W       = 48;
  localparam int HASH_TABLE_W = 64;
  localparam int HASH_IDX_W   = 6;
  localparam int NUM_SLOTS    = 3;
  localparam int USED_W       = 2;
  localparam int UNICAST_SLOTS = 3;

  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam int          HASH_SHIFT = 26;

  // Clamp the slot count into 1..NUM_SLOTS.
  localparam int SLOT_LIMIT_I = (UNICAST_SLOTS < 1) ? 1 :
                                ((UNICAST_SLOTS > NUM_SLOTS) ? NUM_SLOTS : UNICAST_SLOTS);
  localparam logic [USED_W-1:0] SLOT_LIMIT = USED_W'(SLOT_LIMIT_I);

  typedef struct packed {
    logic              first_entry;
    logic              entry_valid;
    logic [ADDR_W-1:0] mac_addr;
  } maf_in_t;

  typedef struct packed {
    logic [HASH_TABLE_W-1:0] hash_table;
    logic [ADDR_W-1:0]       unicast_addr_0;
    logic [ADDR_W-1:0]       unicast_addr_1;
    logic [ADDR_W-1:0]       unicast_addr_2;
    logic [NUM_SLOTS-1:0]    unicast_enables;
  } maf_out_t;

  // One filter update, handed from the input stage to the filter state.
  typedef struct packed {
    logic                  advance;
    logic                  first_entry;
    logic                  entry_valid;
    logic [ADDR_W-1:0]     mac_addr;
    logic [HASH_IDX_W-1:0] hash_idx;
  } maf_upd_t;

  // Ethernet CRC-32 of a 48-bit address, bits taken LSB first from byte 0.
  // Used at elaboration only, to derive the hash XOR masks.
  function automatic logic [31:0] maf_crc32(input logic [ADDR_W-1:0] addr);
    logic [31:0] crc;
    logic        fb;
    crc = CRC_PRESET;
    for (int b = 0; b < ADDR_W; b++) begin
      fb  = crc[31] ^ addr[b];
      crc = {crc[30:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return ~crc;
  endfunction

  // Hash index bits for the all-zero address (the affine offset).
  function automatic logic [HASH_IDX_W-1:0] maf_hash_base();
    logic [31:0] crc;
    crc = maf_crc32('0);
    return crc[HASH_SHIFT +: HASH_IDX_W];
  endfunction

  // Per hash bit, the address bits that feed it by XOR.
  function automatic logic [HASH_IDX_W-1:0][ADDR_W-1:0] maf_hash_masks();
    logic [HASH_IDX_W-1:0][ADDR_W-1:0] m;
    logic [31:0]                       c0;
    logic [31:0]                       cj;
    logic [ADDR_W-1:0]                 one_bit;
    c0 = maf_crc32('0);
    m  = '0;
    for (int j = 0; j < ADDR_W; j++) begin
      one_bit    = '0;
      one_bit[j] = 1'b1;
      cj         = maf_crc32(one_bit) ^ c0;
      for (int i = 0; i < HASH_IDX_W; i++) begin
        m[i][j] = cj[HASH_SHIFT + i];
      end
    end
    return m;
  endfunction

  localparam logic [HASH_IDX_W-1:0]             HASH_BASE  = maf_hash_base();
  localparam logic [HASH_IDX_W-1:0][ADDR_W-1:0] HASH_MASKS = maf_hash_masks();

endpackage

// File: src/maf_hash.sv
// ---------------------------------------------------------------------------
// maf_hash
// Multicast hash index: CRC-32 bits 31:26 of the address as XOR trees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module maf_hash (
  input  logic [maf_pkg::ADDR_W-1:0]     mac_addr,
  output logic [maf_pkg::HASH_IDX_W-1:0] hash_idx
);
  import maf_pkg::*;

  always_comb begin
    for (int i = 0; i < HASH_IDX_W; i++) begin
      hash_idx[i] = (^(mac_addr & HASH_MASKS[i])) ^ HASH_BASE[i];
    end
  end

endmodule

// File: src/maf_filt.sv
// ---------------------------------------------------------------------------
// maf_filt
// Filter state: hash table, unicast slots and fill count; also the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module maf_filt (
  input  logic              clk,
  input  logic              rst_n,
  input  maf_pkg::maf_upd_t upd,
  output maf_pkg::maf_out_t filt
);
  import maf_pkg::*;

  logic [HASH_TABLE_W-1:0] hash_r, hash_nxt;
  logic [ADDR_W-1:0]       slot_r   [NUM_SLOTS];
  logic [ADDR_W-1:0]       slot_nxt [NUM_SLOTS];
  logic [USED_W-1:0]       used_r, used_nxt;

  always_comb begin
    // Start from cleared state on a first entry.
    hash_nxt = upd.first_entry ? '0 : hash_r;
    used_nxt = upd.first_entry ? '0 : used_r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_nxt[i] = upd.first_entry ? '0 : slot_r[i];
    end
    if (upd.entry_valid) begin
      if (upd.mac_addr[0]) begin
        hash_nxt = hash_nxt | (HASH_TABLE_W'(1) << upd.hash_idx);
      end else if (used_nxt < SLOT_LIMIT) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (used_nxt == USED_W'(i)) begin
            slot_nxt[i] = upd.mac_addr;
          end
        end
        used_nxt = used_nxt + USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      used_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else if (upd.advance) begin
      hash_r <= hash_nxt;
      used_r <= used_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  always_comb begin
    filt.hash_table     = hash_r;
    filt.unicast_addr_0 = slot_r[0];
    filt.unicast_addr_1 = slot_r[1];
    filt.unicast_addr_2 = slot_r[2];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      filt.unicast_enables[i] = (used_r > USED_W'(i));
    end
  end

endmodule

// File: src/mac_address_filter_builder.sv
// ---------------------------------------------------------------------------
// mac_address_filter_builder
// Builds a multicast hash table and unicast perfect-match slots from entries.
// ---------------------------------------------------------------------------
//
//   channel | ports                              | payload
//   --------+------------------------------------+--------------------------
//   in      | in_valid, in_ready, in_data        | first flag, valid, MAC
//   out     | out_valid, out_ready, out_data     | hash table, slots, enables
//
// Flow: one item per clock while out_ready stays high; a taken item loads the
// input register, and the filter/result register loads it as the item
// advances; an item waits there while an unread result is held.
// The CRC hash is a set of 48-input XOR trees between the input register and
// the filter state register.
// Reset: rst_n low clears both valid bits and the whole filter to zero.
// Stalls: a held result blocks the input register only; one more item is
// still taken while the result waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mac_address_filter_builder_macros.svh"

module mac_address_filter_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  maf_pkg::maf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output maf_pkg::maf_out_t out_data
);
  import maf_pkg::*;

  // Input stage: hold one accepted item.
  maf_in_t               in_r;
  logic                  s1_v_r, s1_v_nxt;
  logic                  out_v_r, out_v_nxt;
  logic                  s1_adv;
  logic                  in_acc;
  logic [HASH_IDX_W-1:0] hash_idx;
  maf_upd_t              upd;

  // Advance the held item into the filter once the result slot is free.
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  maf_hash u_hash (
    .mac_addr (in_r.mac_addr),
    .hash_idx (hash_idx)
  );

  always_comb begin
    upd.advance     = s1_adv;
    upd.first_entry = in_r.first_entry;
    upd.entry_valid = in_r.entry_valid;
    upd.mac_addr    = in_r.mac_addr;
    upd.hash_idx    = hash_idx;
  end

  // The filter state doubles as the result register: it changes only when
  // an item advances, which needs the previous result to be gone.
  maf_filt u_filt (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .filt  (out_data)
  );

  assign out_valid = out_v_r;

  // Every advance produces a result on the next cycle.
  `MAF_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid, "advance without result")
  // The filter never moves without an item advancing.
  `MAF_ASSERT_NEXT(a_state_holds, !s1_adv, $stable(out_data), "filter changed while idle")
  // Enables fill from slot 0 upward.
  `MAF_ASSERT_NOW(a_enables_therm, 1'b1,
    out_data.unicast_enables == 3'b000 || out_data.unicast_enables == 3'b001 ||
    out_data.unicast_enables == 3'b011 || out_data.unicast_enables == 3'b111,
    "unicast enables not contiguous")

endmodule
